[hdl/text_console_cursor_engine_macros.svh]
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Shorthand for clocked implication checks, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_CHECK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCE_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

[hdl/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Text console package
// Shared types and character codes of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Operation code carried with every input item.
    typedef logic [1:0] func_t;

    localparam func_t FUNC_PUT   = 2'd0;
    localparam func_t FUNC_CLEAR = 2'd1;
    localparam func_t FUNC_READ  = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [7:0] BACKSPACE_CHAR = 8'h08;

    // Attribute byte after reset.
    localparam logic [7:0] COLOR_AT_RESET = 8'h0F;

    // One screen cell: attribute in the high byte, character in the low byte.
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] chr;
    } cell_t;

    // What a put operation asks of the cell store.
    typedef struct packed {
        logic write;
        logic scroll;
    } put_ctl_t;

endpackage

[hdl/tcce_cursor.sv]
// ----------------------------------------------------------------------------
// Text console cursor
// Holds the cursor as row, column and linear cell address, and works out
// the cursor move, the cell write and the need to scroll for a put byte.
// ----------------------------------------------------------------------------
module tcce_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS),
    localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                put_en,
    input  logic                clear_en,
    input  logic [7:0]          char_code,
    output logic [ROW_W-1:0]    row,
    output logic [COL_W-1:0]    col,
    output logic [ADDR_W-1:0]   addr,
    output logic [ROW_W-1:0]    row_next,
    output logic [COL_W-1:0]    col_next,
    output logic [ADDR_W-1:0]   wr_addr,
    output tcce_pkg::put_ctl_t  ctl
);
    import tcce_pkg::*;

    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] addr_next;
    logic              is_bs;
    logic              is_nl;
    logic              is_print;
    logic              last_row;
    logic              last_col;

    assign is_bs    = (char_code == BACKSPACE_CHAR);
    assign is_nl    = (char_code == NEWLINE_CHAR);
    assign is_print = (char_code >= BLANK_CHAR) && !char_code[7];
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign last_col = (col_reg == COL_W'(COLUMNS - 1));

    // Cursor move for one put byte.
    always_comb
    begin
        put_row    = row_reg;
        put_col    = col_reg;
        put_addr   = addr_reg;
        ctl.write  = 1'b0;
        ctl.scroll = 1'b0;
        if (is_bs)
        begin
            // Step back, wrapping to the previous row; the home cell stays put.
            ctl.write = 1'b1;
            if (col_reg != '0)
            begin
                put_col  = col_reg - COL_W'(1);
                put_addr = addr_reg - ADDR_W'(1);
            end
            else if (row_reg != '0)
            begin
                put_row  = row_reg - ROW_W'(1);
                put_col  = COL_W'(COLUMNS - 1);
                put_addr = addr_reg - ADDR_W'(1);
            end
        end
        else if (is_nl || is_print)
        begin
            ctl.write = is_print;
            if (is_nl || last_col)
            begin
                put_col = '0;
                if (last_row)
                begin
                    ctl.scroll = 1'b1;
                    put_addr   = ADDR_W'(LAST_BASE);
                end
                else
                begin
                    put_row  = row_reg + ROW_W'(1);
                    put_addr = addr_reg - ADDR_W'(col_reg) + ADDR_W'(COLUMNS);
                end
            end
            else
            begin
                put_col  = col_reg + COL_W'(1);
                put_addr = addr_reg + ADDR_W'(1);
            end
        end
    end

    // A backspace blanks the cell it lands on, a printable byte its own cell.
    assign wr_addr = is_bs ? put_addr : addr_reg;

    // Next cursor: clear homes it, a put moves it.
    always_comb
    begin
        priority if (clear_en)
        begin
            row_next  = '0;
            col_next  = '0;
            addr_next = '0;
        end
        else if (put_en)
        begin
            row_next  = put_row;
            col_next  = put_col;
            addr_next = put_addr;
        end
        else
        begin
            row_next  = row_reg;
            col_next  = col_reg;
            addr_next = addr_reg;
        end
    end

    // Cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            addr_reg <= addr_next;
        end
    end

    assign row  = row_reg;
    assign col  = col_reg;
    assign addr = addr_reg;

endmodule

[hdl/text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// Text console cursor engine
// Text mode screen store of ROWS x COLUMNS character and attribute cells,
// with a cursor, scrolling, clear and cell read-back.
// ----------------------------------------------------------------------------
// One item is in work at a time. A read goes through the registered read
// port of the cell store; a clear writes one cell a cycle; a put that
// scrolls copies each row up one cell a cycle and then blanks the last row.
// The single write port of the cell store is why clear and scroll go one
// cell at a time. A new item is taken once the previous result has been
// transferred or is being transferred in that cycle. The cell store is not
// cleared by reset; read only cells written since the first clear.
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  tcce_pkg::func_t   func,
    input  logic [7:0]        char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        cell_char,
    output logic [7:0]        cell_color,
    output logic [ROW_W-1:0]  caret_row,
    output logic [COL_W-1:0]  caret_col
);
    import tcce_pkg::*;

    localparam int DEPTH     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_BLANK = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [7:0]        color_reg;
    logic              rd_ok_reg;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_color_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    logic              out_free;
    logic              in_xfer;
    logic              put_go;
    logic              clr_go;
    logic              rd_go;
    logic              rd_in_range;
    logic              finish;
    logic [7:0]        fin_char;
    logic [7:0]        fin_color;

    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ADDR_W-1:0] cur_addr;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] put_wr_addr;
    put_ctl_t          put_ctl;

    cell_t             mem [DEPTH];
    cell_t             rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    cell_t             mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  copy_dst;
    cell_t             blank_cell;

    // Input handshake: one item at a time, output register free or draining.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_xfer  = in_valid && !in_stall;
    assign put_go   = in_xfer && (func == FUNC_PUT);
    assign clr_go   = in_xfer && (func == FUNC_CLEAR);
    assign rd_go    = in_xfer && (func == FUNC_READ);

    // Attribute register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_AT_RESET;
        end
        else if (cfg_wr_en)
        begin
            color_reg <= cfg_wr_data;
        end
    end

    // Cursor and put decode.
    tcce_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .put_en    (put_go),
        .clear_en  (clr_go),
        .char_code (char_code),
        .row       (cur_row),
        .col       (cur_col),
        .addr      (cur_addr),
        .row_next  (row_next),
        .col_next  (col_next),
        .wr_addr   (put_wr_addr),
        .ctl       (put_ctl)
    );

    // Read address of a read item.
    assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
    assign rd_addr     = ADDR_W'(int'(read_row) * COLUMNS + int'(read_col));
    assign copy_dst    = cnt_reg - CNT_W'(COLUMNS + 1);
    assign blank_cell  = '{color: color_reg, chr: BLANK_CHAR};

    // Cell store port selection by state.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = put_wr_addr;
        mem_wd = blank_cell;
        mem_re = 1'b0;
        mem_ra = rd_addr;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we = put_go && put_ctl.write;
                mem_wd = '{color: color_reg,
                           chr: (char_code == BACKSPACE_CHAR) ? BLANK_CHAR : char_code};
                mem_re = rd_go && rd_in_range;
            end
            ST_COPY:
            begin
                // Read one cell ahead, write the cell read in the previous cycle a row up.
                mem_we = (cnt_reg != CNT_W'(COLUMNS));
                mem_wa = copy_dst[ADDR_W-1:0];
                mem_wd = rd_data_reg;
                mem_re = (cnt_reg != CNT_W'(DEPTH));
                mem_ra = cnt_reg[ADDR_W-1:0];
            end
            ST_BLANK, ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[ADDR_W-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Cell store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Sequencer for reads, scroll and clear.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (put_go && put_ctl.scroll)
                begin
                    state_next = ST_COPY;
                    cnt_next   = CNT_W'(COLUMNS);
                end
                else if (clr_go)
                begin
                    state_next = ST_CLEAR;
                    cnt_next   = '0;
                end
                else if (rd_go)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    finish = in_xfer;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                finish     = 1'b1;
            end
            ST_COPY:
            begin
                if (cnt_reg == CNT_W'(DEPTH))
                begin
                    state_next = ST_BLANK;
                    cnt_next   = CNT_W'(LAST_BASE);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                    finish     = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (rd_go)
            begin
                rd_ok_reg <= rd_in_range;
            end
        end
    end

    // Cell fields of the result: only a read in range returns the cell.
    assign fin_char  = ((state_reg == ST_READ) && rd_ok_reg) ? rd_data_reg.chr : 8'h00;
    assign fin_color = ((state_reg == ST_READ) && rd_ok_reg) ? rd_data_reg.color : 8'h00;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_char_reg  <= fin_char;
            out_color_reg <= fin_color;
            out_row_reg   <= row_next;
            out_col_reg   <= col_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cell_color = out_color_reg;
    assign caret_row  = out_row_reg;
    assign caret_col  = out_col_reg;

    // A long operation never overlaps a pending result.
    `TCCE_CHECK_SAME(a_busy_no_result, state_reg != ST_IDLE, !out_valid_reg)
    // The cursor stays on the screen.
    `TCCE_CHECK_SAME(a_cursor_bounds, 1'b1, (int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS))
    // The linear cursor address tracks row and column.
    `TCCE_CHECK_SAME(a_cursor_addr, 1'b1,
                     int'(cur_addr) == (int'(cur_row) * COLUMNS + int'(cur_col)))
    // A put that does not scroll delivers its result in the next cycle.
    `TCCE_CHECK_NEXT(a_put_result, put_go && !put_ctl.scroll, out_valid_reg)

endmodule
